FILE: hdl/gpbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpbp_pkg
// Shared types and constants for the gray pixel bit packer.
// ----------------------------------------------------------------------------
package gpbp_pkg;

  localparam int AccBits = 40;

  // out_mode codes
  localparam logic [1:0] ModeRaw8  = 2'd0;
  localparam logic [1:0] ModeRaw10 = 2'd1;
  localparam logic [1:0] ModeRaw12 = 2'd2;

  localparam logic [1:0] ModeReset = ModeRaw10;

  // one packed group handed from the front to the back
  typedef struct packed {
    logic [AccBits-1:0] data;     // first pixel in the lowest bits
    logic [2:0]         nbytes;   // 1 to 5
    logic               row_end;
  } grp_t;

endpackage

`default_nettype wire

FILE: hdl/gpbp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpbp_front
// Accepts pixels, accumulates them into a group and emits finished groups.
// ----------------------------------------------------------------------------
module gpbp_front import gpbp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [1:0] mode_i,
  input  wire logic       clear_i,
  input  wire logic       accept_i,
  input  wire logic [15:0] pixel_i,
  input  wire logic       row_end_i,
  output logic            grp_push_o,
  output grp_t            grp_o
);

  logic [AccBits-1:0] acc_q, acc_d;
  logic [1:0]         cnt_q, cnt_d;
  logic [AccBits-1:0] pix_shift;
  logic [AccBits-1:0] acc_new;
  logic [2:0]         cnt_new;
  logic               emit;
  logic [2:0]         nbytes;
  logic               is_raw8;

  assign is_raw8 = (mode_i != ModeRaw10) && (mode_i != ModeRaw12);

  always_comb begin
    pix_shift = '0;
    cnt_new   = 3'd1;
    if (mode_i == ModeRaw10) begin
      case (cnt_q)
        2'd0:    pix_shift = {30'd0, pixel_i[9:0]};
        2'd1:    pix_shift = {20'd0, pixel_i[9:0], 10'd0};
        2'd2:    pix_shift = {10'd0, pixel_i[9:0], 20'd0};
        2'd3:    pix_shift = {pixel_i[9:0], 30'd0};
        default: pix_shift = '0;
      endcase
      cnt_new = {1'b0, cnt_q} + 3'd1;
    end else begin
      // a count of two or more cannot be held in 12-bit mode; treat as start
      if (cnt_q == 2'd1) begin
        pix_shift = {16'd0, pixel_i[11:0], 12'd0};
        cnt_new   = 3'd2;
      end else begin
        pix_shift = {28'd0, pixel_i[11:0]};
        cnt_new   = 3'd1;
      end
    end
    acc_new = acc_q | pix_shift;
  end

  always_comb begin
    emit   = 1'b1;
    nbytes = 3'd1;
    if (is_raw8) begin
      emit   = 1'b1;
      nbytes = 3'd1;
    end else if (mode_i == ModeRaw10) begin
      emit = (cnt_new == 3'd4) || row_end_i;
      // ceil(10 * n / 8) = n + 1 for n = 1..4
      nbytes = cnt_new + 3'd1;
    end else begin
      emit   = (cnt_new == 3'd2) || row_end_i;
      nbytes = (cnt_new == 3'd2) ? 3'd3 : 3'd2;
    end
  end

  always_comb begin
    grp_o.data    = is_raw8 ? {32'd0, pixel_i[7:0]} : acc_new;
    grp_o.nbytes  = nbytes;
    grp_o.row_end = row_end_i;
    grp_push_o    = accept_i && emit;
  end

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (clear_i) begin
      acc_d = '0;
      cnt_d = '0;
    end else if (accept_i && !is_raw8) begin
      if (emit) begin
        acc_d = '0;
        cnt_d = '0;
      end else begin
        acc_d = acc_new;
        cnt_d = cnt_new[1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gpbp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpbp_queue
// Two-entry group queue between the front and the back.
// ----------------------------------------------------------------------------
module gpbp_queue import gpbp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire grp_t wdata_i,
  input  wire logic pop_i,
  output grp_t      rdata_o,
  output logic      full_o,
  output logic      empty_o
);

  grp_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gpbp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpbp_back
// Walks the bytes of the queue head into a registered output stage.
// ----------------------------------------------------------------------------
module gpbp_back import gpbp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire grp_t       grp_i,
  input  wire logic       grp_empty_i,
  output logic            grp_pop_o,
  input  wire logic       pop_i,
  output logic            empty_o,
  output logic [7:0]      packed_byte_o,
  output logic            run_last_o,
  output logic            row_done_o
);

  logic [2:0] idx_q, idx_d;
  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       last_q, row_q;
  logic [7:0] byte_sel;
  logic       last_sel;
  logic       load;

  assign load     = !grp_empty_i && (!out_valid_q || pop_i);
  assign last_sel = ((idx_q + 3'd1) == grp_i.nbytes);
  assign grp_pop_o = load && last_sel;

  always_comb begin
    case (idx_q)
      3'd0:    byte_sel = grp_i.data[7:0];
      3'd1:    byte_sel = grp_i.data[15:8];
      3'd2:    byte_sel = grp_i.data[23:16];
      3'd3:    byte_sel = grp_i.data[31:24];
      3'd4:    byte_sel = grp_i.data[39:32];
      default: byte_sel = 8'd0;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = last_sel ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_sel;
      last_q <= last_sel;
      row_q  <= last_sel && grp_i.row_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty_o       = !out_valid_q;
  assign packed_byte_o = byte_q;
  assign run_last_o    = last_q;
  assign row_done_o    = row_q;

endmodule

`default_nettype wire

FILE: hdl/gray_pixel_bit_packer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gray_pixel_bit_packer
// Packs 16-bit gray pixels LSB first into an 8, 10 or 12 bit byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive pixel_i/row_end_i and raise push; the transaction
//   completes on a clock edge with push high and full low.
//   Output queue side: while empty is low the oldest byte sits on
//   packed_byte_o/run_last_o/row_done_o; pop takes it.
//   cfg_we_i writes out_mode (0 = 8, 1 = 10, 2 = 12 bit; 3 acts as 8 bit)
//   and drops any partial group. Write it only while the block is idle.
// Path: a pixel that closes a group goes into the group queue, then its first
//   byte is registered out; the rest follow one per cycle while pop is high.
// Throughput: one pixel per cycle in the front while full is low; the back
//   drains one byte per cycle while popped, so 10-bit mode packs 4 pixels
//   into 5 bytes and 12-bit mode 2 into 3. The byte-wide output stage sets the rate.
// Stalls: a two-entry group queue decouples the sides; full rises when it
//   holds two groups not yet started or in progress.
// Reset: out_mode returns to 10 bit, queue and accumulator are cleared.
// ----------------------------------------------------------------------------
module gray_pixel_bit_packer import gpbp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_wdata_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] pixel_i,
  input  wire logic        row_end_i,
  input  wire logic        pop,
  output logic             empty,
  output logic [7:0]       packed_byte_o,
  output logic             run_last_o,
  output logic             row_done_o
);

  logic [1:0] mode_q;
  logic       accept;
  logic       q_push, q_pop, q_full, q_empty;
  grp_t       q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeReset;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  gpbp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (mode_q),
    .clear_i    (cfg_we_i),
    .accept_i   (accept),
    .pixel_i    (pixel_i),
    .row_end_i  (row_end_i),
    .grp_push_o (q_push),
    .grp_o      (q_wdata)
  );

  gpbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  gpbp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .grp_i         (q_rdata),
    .grp_empty_i   (q_empty),
    .grp_pop_o     (q_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .packed_byte_o (packed_byte_o),
    .run_last_o    (run_last_o),
    .row_done_o    (row_done_o)
  );

  // a finished row always ends a group
  a_row_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && row_done_o) |-> run_last_o)
    else $error("row_done without run_last");

  // the front never hands a group to a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("group pushed into full queue");

  // a new output byte only comes from a queued group
  a_load_from_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> $past(!q_empty))
    else $error("output loaded from empty queue");

  // the back never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule

`default_nettype wire
